>>> rtl/tlbfdp_pkg.sv
// ----------------------------------------------------------------------------
// tlbfdp_pkg
// Shared types and constants for the FIFO TLB / demand-paged translator.
// ----------------------------------------------------------------------------
package tlbfdp_pkg;

    // Address split
    localparam int ADDR_BITS   = 32;
    localparam int OFFSET_BITS = 12;
    localparam int FRAME_BITS  = 20;

    // Result transaction: physical_address, tlb_hit, fault flag, zero padded
    localparam int OUT_DATA_BITS = 40;
    localparam int OUT_HIT_BIT   = 32;
    localparam int OUT_FAULT_BIT = 33;

    // Configuration
    localparam int             CFG_DATA_BITS  = 32;
    localparam int             CFG_ADDR_BITS  = 3;
    localparam int             CFG_FIELD_BITS = 5;
    localparam int             CAP_RESET      = 4;
    localparam logic           REG_TLB_CAPACITY = 1'b0;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_LOOK  = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    // Control sent down the row of TLB cells
    typedef struct packed {
        logic shift;
        logic flush;
    } cell_ctrl_t;

endpackage

>>> rtl/tlb_fifo_demand_page_translator_unit.sv
// ----------------------------------------------------------------------------
// tlb_fifo_demand_page_translator_unit
// Virtual to physical translation through a FIFO TLB backed by a
// demand-filled page table.
// ----------------------------------------------------------------------------
// After reset the page table valid map is wiped by a clearing pass over all
// 2**PAGE_NUMBER_BITS entries (1,048,576 at the default), during which no
// input transaction is taken; configuration writes are taken throughout.
// Items are handled one at a time: a TLB hit goes through the accept, then
// the registered lookup across the row of TLB cells; a miss adds the
// registered read of the page table RAM, with the allocation write-back
// made in the same cycle the result is issued. The TLB is a row of
// TLB_MAX cells that shifts by one on each insertion, so the oldest entry
// falls off the end of the active capacity. Writing tlb_capacity (0 reads as
// 1, values above TLB_MAX saturate) flushes the TLB; the page table and the
// frame counter are kept. The result channel has a one-deep output register,
// so the next input is taken while a result still waits.
// ----------------------------------------------------------------------------
module tlb_fifo_demand_page_translator_unit #(
    parameter int TLB_MAX          = 16,
    parameter int PAGE_NUMBER_BITS = 20
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // Input channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [tlbfdp_pkg::ADDR_BITS-1:0]       s_tdata,  // [31:0] virtual_address
    // Result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [tlbfdp_pkg::OUT_DATA_BITS-1:0]   m_tdata,  // [31:0] physical_address,
                                                             // [32] tlb_hit,
                                                             // [33] fault, [39:34] 0
    // Configuration port
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [tlbfdp_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [tlbfdp_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [tlbfdp_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                   pready
);

    localparam int PNB      = PAGE_NUMBER_BITS;
    localparam int CW       = $clog2(TLB_MAX + 1);
    localparam int FB       = tlbfdp_pkg::FRAME_BITS;
    localparam int OB       = tlbfdp_pkg::OFFSET_BITS;
    localparam int RAM_W    = FB + 1;
    localparam int CAP_INIT = (tlbfdp_pkg::CAP_RESET > TLB_MAX) ? TLB_MAX
                                                                : tlbfdp_pkg::CAP_RESET;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    tlbfdp_pkg::state_t                      state_reg, state_next;
    logic [tlbfdp_pkg::ADDR_BITS-1:0]        va_reg;
    logic [PNB-1:0]                          clr_reg, clr_next;
    logic [FB-1:0]                           nfc_reg, nfc_next;
    logic [CW-1:0]                           cap_reg, cap_next;
    logic                                    m_tvalid_reg, m_tvalid_next;
    logic [tlbfdp_pkg::OUT_DATA_BITS-1:0]    m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic                                    cfg_wr;
    logic                                    cfg_sel_cap;
    logic [6:0]                              cfg_val;

    assign pready      = 1'b1;
    assign cfg_sel_cap = (paddr[2] == tlbfdp_pkg::REG_TLB_CAPACITY);
    assign cfg_wr      = psel && penable && pwrite && cfg_sel_cap;
    assign cfg_val     = {2'b00, pwdata[tlbfdp_pkg::CFG_FIELD_BITS-1:0]};
    assign prdata      = cfg_sel_cap ? tlbfdp_pkg::CFG_DATA_BITS'(cap_reg) : '0;

    // Saturate the written capacity to 1..TLB_MAX
    always_comb begin
        cap_next = cap_reg;
        if (cfg_wr) begin
            if (cfg_val == 7'd0) begin
                cap_next = CW'(1);
            end else if (cfg_val > 7'(TLB_MAX)) begin
                cap_next = CW'(TLB_MAX);
            end else begin
                cap_next = CW'(cfg_val);
            end
        end
    end

    // ------------------------------------------------------------------
    // TLB row of cells
    // ------------------------------------------------------------------
    tlbfdp_pkg::cell_ctrl_t  cell_ctrl;
    logic [PNB-1:0]          look_page;
    logic [OB-1:0]           look_off;
    logic [FB-1:0]           ins_frame;
    logic                    c_valid [TLB_MAX];
    logic [PNB-1:0]          c_page  [TLB_MAX];
    logic [FB-1:0]           c_frame [TLB_MAX];
    logic                    c_match [TLB_MAX];
    logic                    hit_any;
    logic [FB-1:0]           hit_frame;

    assign look_page = va_reg[OB +: PNB];
    assign look_off  = va_reg[OB-1:0];

    for (genvar i = 0; i < TLB_MAX; i++) begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic room;
        assign room = (IDX < cap_reg);
        if (i == 0) begin : g_head
            tlbfdp_cell #(.PAGE_BITS(PNB)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .room       (room),
                .prev_valid (1'b1),
                .prev_page  (look_page),
                .prev_frame (ins_frame),
                .look_page  (look_page),
                .valid      (c_valid[i]),
                .page       (c_page[i]),
                .frame      (c_frame[i]),
                .match      (c_match[i])
            );
        end else begin : g_body
            tlbfdp_cell #(.PAGE_BITS(PNB)) u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .room       (room),
                .prev_valid (c_valid[i-1]),
                .prev_page  (c_page[i-1]),
                .prev_frame (c_frame[i-1]),
                .look_page  (look_page),
                .valid      (c_valid[i]),
                .page       (c_page[i]),
                .frame      (c_frame[i]),
                .match      (c_match[i])
            );
        end
    end

    // Combine cell matches; entries are unique so at most one matches
    always_comb begin
        hit_any   = 1'b0;
        hit_frame = '0;
        for (int i = 0; i < TLB_MAX; i++) begin
            hit_any   = hit_any | c_match[i];
            hit_frame = hit_frame | (c_match[i] ? c_frame[i] : '0);
        end
    end

    // ------------------------------------------------------------------
    // Page table RAM: {valid, frame}
    // ------------------------------------------------------------------
    logic               pt_we;
    logic [PNB-1:0]     pt_waddr;
    logic [RAM_W-1:0]   pt_wdata;
    logic               pt_re;
    logic [RAM_W-1:0]   pt_rdata;
    logic               pt_valid;

    assign pt_valid = pt_rdata[FB];

    tlbfdp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (2 ** PNB)
    ) u_page_table (
        .aclk  (aclk),
        .we    (pt_we),
        .waddr (pt_waddr),
        .wdata (pt_wdata),
        .re    (pt_re),
        .raddr (look_page),
        .rdata (pt_rdata)
    );

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    logic out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == tlbfdp_pkg::ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        nfc_next        = nfc_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        pt_we           = 1'b0;
        pt_waddr        = look_page;
        pt_wdata        = '0;
        pt_re           = 1'b0;
        ins_frame       = pt_valid ? pt_rdata[FB-1:0] : nfc_reg;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.flush = cfg_wr;

        // Output register drains
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            tlbfdp_pkg::ST_CLEAR: begin
                pt_we    = 1'b1;
                pt_waddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {PNB{1'b1}}) begin
                    state_next = tlbfdp_pkg::ST_IDLE;
                end
            end
            tlbfdp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = tlbfdp_pkg::ST_LOOK;
                end
            end
            tlbfdp_pkg::ST_LOOK: begin
                if (!hit_any) begin
                    // Miss: fetch the page table entry
                    pt_re      = 1'b1;
                    state_next = tlbfdp_pkg::ST_READ;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[tlbfdp_pkg::ADDR_BITS-1:0] = {hit_frame, look_off};
                    m_tdata_next[tlbfdp_pkg::OUT_HIT_BIT]   = 1'b1;
                    state_next    = tlbfdp_pkg::ST_IDLE;
                end
            end
            tlbfdp_pkg::ST_READ: begin
                if (out_free) begin
                    // Allocate a frame on first touch of the page
                    if (!pt_valid) begin
                        pt_we    = 1'b1;
                        pt_wdata = {1'b1, nfc_reg};
                        nfc_next = nfc_reg + 1'b1;
                    end
                    cell_ctrl.shift = 1'b1;
                    m_tvalid_next   = 1'b1;
                    m_tdata_next    = '0;
                    m_tdata_next[tlbfdp_pkg::ADDR_BITS-1:0] = {ins_frame, look_off};
                    m_tdata_next[tlbfdp_pkg::OUT_FAULT_BIT] = !pt_valid;
                    state_next      = tlbfdp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tlbfdp_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tlbfdp_pkg::ST_CLEAR;
            clr_reg      <= '0;
            nfc_reg      <= '0;
            cap_reg      <= CW'(CAP_INIT);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            nfc_reg      <= nfc_next;
            cap_reg      <= cap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            va_reg <= s_tdata;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/tlbfdp_ram.sv
// ----------------------------------------------------------------------------
// tlbfdp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tlbfdp_ram #(
    parameter int WIDTH = 21,
    parameter int DEPTH = 1048576
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tlbfdp_cell.sv
// ----------------------------------------------------------------------------
// tlbfdp_cell
// One TLB entry in the FIFO row: holds page/frame, compares against the
// lookup page and passes its entry on to the next cell on insertion.
// ----------------------------------------------------------------------------
module tlbfdp_cell #(
    parameter int PAGE_BITS = 20
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tlbfdp_pkg::cell_ctrl_t           ctrl,
    input  logic                             room,       // cell lies within capacity
    input  logic                             prev_valid,
    input  logic [PAGE_BITS-1:0]             prev_page,
    input  logic [tlbfdp_pkg::FRAME_BITS-1:0] prev_frame,
    input  logic [PAGE_BITS-1:0]             look_page,
    output logic                             valid,
    output logic [PAGE_BITS-1:0]             page,
    output logic [tlbfdp_pkg::FRAME_BITS-1:0] frame,
    output logic                             match
);

    logic                              valid_reg;
    logic [PAGE_BITS-1:0]              page_reg;
    logic [tlbfdp_pkg::FRAME_BITS-1:0] frame_reg;

    // Valid bit: cleared on flush, entry beyond capacity drops out of the row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.flush) begin
            valid_reg <= 1'b0;
        end else if (ctrl.shift) begin
            valid_reg <= prev_valid & room;
        end
    end

    // Entry payload
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            page_reg  <= prev_page;
            frame_reg <= prev_frame;
        end
    end

    assign match = valid_reg && (page_reg == look_page);
    assign valid = valid_reg;
    assign page  = page_reg;
    assign frame = frame_reg;

endmodule

>>> rtl/tlbfdp_checker.sv
// ----------------------------------------------------------------------------
// tlbfdp_checker
// Port-level assertions for the translator, bound to the top level.
// ----------------------------------------------------------------------------
module tlbfdp_checker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [tlbfdp_pkg::OUT_DATA_BITS-1:0] m_tdata
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A TLB hit never reports a fault
    a_hit_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[tlbfdp_pkg::OUT_HIT_BIT] && m_tdata[tlbfdp_pkg::OUT_FAULT_BIT]))
        else $error("hit and fault together");

    // Reset starts the clearing pass: no input taken
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready straight after reset");

    // One item in flight: an accepted transaction closes the input
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while busy");

    // A new result only follows a busy cycle
    a_result_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without an item in progress");

endmodule

bind tlb_fifo_demand_page_translator_unit tlbfdp_checker u_tlbfdp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
